FILE: rtl/sorted_integer_set_unit_assert.svh
// assertion macros for the sorted integer set unit
// used by the checker; no other dependencies
`ifndef SORTED_INTEGER_SET_UNIT_ASSERT_SVH
`define SORTED_INTEGER_SET_UNIT_ASSERT_SVH

// clocked assertion, off while reset is high
`define SISU_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked assertion that also holds through reset
`define SISU_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/sis_pkg.sv
// shared types, constants and micro-operation codes for the sorted integer set unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sis_pkg;
   localparam int CAPACITY = 256;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = 9;
   localparam int DATA_W   = 32;

   localparam logic [2:0] CMD_INSERT = 3'd0;
   localparam logic [2:0] CMD_APPEND = 3'd1;
   localparam logic [2:0] CMD_AT     = 3'd2;
   localparam logic [2:0] CMD_FIND   = 3'd3;
   localparam logic [2:0] CMD_SORT   = 3'd4;
   localparam logic [2:0] CMD_CLEAR  = 3'd5;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_DUP     = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_BADPOS  = 2'd3;

   typedef struct packed {
      logic [2:0]               command;
      logic signed [DATA_W-1:0] value;
      logic [8:0]               position;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       found;
      logic [8:0] where;
      logic [8:0] count;
      logic       ordered;
   } rsp_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_ACCEPT, OP_BS_RD, OP_BS_UPD, OP_EQ_RD, OP_EQ_CHK, OP_BS_MISS,
      OP_LS_RD, OP_LS_CHK, OP_LS_MISS, OP_PLACE, OP_UOA_RD, OP_UOA_CHK, OP_UOB_RD,
      OP_UOB_CHK, OP_UO_SET, OP_SH_RD, OP_SH_WR, OP_INS_DONE, OP_SRT_INIT,
      OP_SRT_RD, OP_SRT_LOAD, OP_SRT_SKIP, OP_SRT_PLACE, OP_SRT_DONE, OP_SRT_END,
      OP_RSP_BADPOS, OP_RSP_DUP, OP_RSP_FULL, OP_RSP_FIND, OP_RSP_PLAIN, OP_CLEAR
   } op_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic       ord;
      logic       full;
      logic       pos_bad;
      logic       lo_lt_hi;
      logic       lo_lt_n;
      logic       i_lt_n;
      logic       match;
      logic       found;
      logic       need_uo;
      logic       p_gt0;
      logic       p_lt_cnt;
      logic       i_gt_p;
      logic       s_lt_cnt;
   } dp_status_type;
endpackage
`default_nettype wire

FILE: rtl/sorted_integer_set_unit.sv
// top level of the sorted integer set unit: controller plus datapath
// depends on sis_pkg, sis_ctrl, sis_dp and sis_ram
//
// A command word is taken when start is high and busy is low; exactly one
// result word follows, shown for a single cycle with rsp_valid, and it cannot
// be held off, so capture it when it appears. busy drops in the cycle that the
// result is shown, so a new command may be taken then. Every table read of a
// command goes through the single, registered read port of the table memory:
// clear and sort of an ordered table need no table access, an ordered find
// uses a binary search, an unordered find a linear search, an insert shifts
// the entries from the insert position up, and sorting an unordered table
// costs a binary search per entry and a shift for each entry that is kept.
`timescale 1ns / 1ps
`default_nettype none
module sorted_integer_set_unit import sis_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);
   op_type        op;
   dp_status_type st;

   sis_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .st    (st),
      .busy  (busy),
      .op    (op)
   );

   sis_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .req_data  (req_data),
      .st        (st),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );
endmodule
`default_nettype wire

FILE: rtl/sis_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module sis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: rtl/sis_ctrl.sv
// controller state machine for the sorted integer set unit
// depends on sis_pkg
`timescale 1ns / 1ps
`default_nettype none
module sis_ctrl import sis_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire dp_status_type st,
   output logic               busy,
   output op_type             op
);
   typedef enum logic [15:0] {
      S_IDLE    = 16'h0001, S_DISP   = 16'h0002, S_LOC    = 16'h0004,
      S_BS_W    = 16'h0008, S_EQ_W   = 16'h0010, S_LS_W   = 16'h0020,
      S_LOC_END = 16'h0040, S_UO_A   = 16'h0080, S_UOA_W  = 16'h0100,
      S_UO_B    = 16'h0200, S_UOB_W  = 16'h0400, S_UO_SET = 16'h0800,
      S_SH      = 16'h1000, S_SH_W   = 16'h2000, S_SRT_RD = 16'h4000,
      S_SRT_LD  = 16'h8000
   } state_type;

   state_type state_ff, state_in;
   logic      sort_ff, sort_in;
   logic      use_bs;

   assign busy   = (state_ff != S_IDLE);
   assign use_bs = sort_ff | st.ord;

   always_comb begin
      state_in = state_ff;
      sort_in  = sort_ff;
      op       = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op       = OP_ACCEPT;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            unique case (st.cmd)
               CMD_INSERT, CMD_APPEND, CMD_AT: begin
                  if (st.cmd == CMD_AT && st.pos_bad) begin
                     op       = OP_RSP_BADPOS;
                     state_in = S_IDLE;
                  end else begin
                     state_in = S_LOC;
                  end
               end
               CMD_FIND: state_in = S_LOC;
               CMD_SORT: begin
                  if (st.ord) begin
                     op       = OP_RSP_PLAIN;
                     state_in = S_IDLE;
                  end else begin
                     op       = OP_SRT_INIT;
                     sort_in  = 1'b1;
                     state_in = S_SRT_RD;
                  end
               end
               CMD_CLEAR: begin
                  op       = OP_CLEAR;
                  state_in = S_IDLE;
               end
               default: begin
                  op       = OP_RSP_PLAIN;
                  state_in = S_IDLE;
               end
            endcase
         end
         S_LOC: begin
            if (use_bs) begin
               priority if (st.lo_lt_hi) begin
                  op       = OP_BS_RD;
                  state_in = S_BS_W;
               end else if (st.lo_lt_n) begin
                  op       = OP_EQ_RD;
                  state_in = S_EQ_W;
               end else begin
                  op       = OP_BS_MISS;
                  state_in = S_LOC_END;
               end
            end else if (st.i_lt_n) begin
               op       = OP_LS_RD;
               state_in = S_LS_W;
            end else begin
               op       = OP_LS_MISS;
               state_in = S_LOC_END;
            end
         end
         S_BS_W: begin
            op       = OP_BS_UPD;
            state_in = S_LOC;
         end
         S_EQ_W: begin
            op       = OP_EQ_CHK;
            state_in = S_LOC_END;
         end
         S_LS_W: begin
            op       = OP_LS_CHK;
            state_in = st.match ? S_LOC_END : S_LOC;
         end
         S_LOC_END: begin
            priority if (sort_ff) begin
               op       = st.found ? OP_SRT_SKIP : OP_SRT_PLACE;
               state_in = st.found ? S_SRT_RD : S_SH;
            end else if (st.cmd == CMD_FIND) begin
               op       = OP_RSP_FIND;
               state_in = S_IDLE;
            end else if (st.found) begin
               op       = OP_RSP_DUP;
               state_in = S_IDLE;
            end else if (st.full) begin
               op       = OP_RSP_FULL;
               state_in = S_IDLE;
            end else begin
               op       = OP_PLACE;
               state_in = S_UO_A;
            end
         end
         S_UO_A: begin
            if (st.need_uo && st.p_gt0) begin
               op       = OP_UOA_RD;
               state_in = S_UOA_W;
            end else begin
               state_in = S_UO_B;
            end
         end
         S_UOA_W: begin
            op       = OP_UOA_CHK;
            state_in = S_UO_B;
         end
         S_UO_B: begin
            if (st.need_uo && st.p_lt_cnt) begin
               op       = OP_UOB_RD;
               state_in = S_UOB_W;
            end else begin
               state_in = S_UO_SET;
            end
         end
         S_UOB_W: begin
            op       = OP_UOB_CHK;
            state_in = S_UO_SET;
         end
         S_UO_SET: begin
            op       = OP_UO_SET;
            state_in = S_SH;
         end
         S_SH: begin
            priority if (st.i_gt_p) begin
               op       = OP_SH_RD;
               state_in = S_SH_W;
            end else if (sort_ff) begin
               op       = OP_SRT_DONE;
               state_in = S_SRT_RD;
            end else begin
               op       = OP_INS_DONE;
               state_in = S_IDLE;
            end
         end
         S_SH_W: begin
            op       = OP_SH_WR;
            state_in = S_SH;
         end
         S_SRT_RD: begin
            if (st.s_lt_cnt) begin
               op       = OP_SRT_RD;
               state_in = S_SRT_LD;
            end else begin
               op       = OP_SRT_END;
               sort_in  = 1'b0;
               state_in = S_IDLE;
            end
         end
         S_SRT_LD: begin
            op       = OP_SRT_LOAD;
            state_in = S_LOC;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sort_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         sort_ff  <= sort_in;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/sis_dp.sv
// datapath: table memory, search and shift registers, result word
// depends on sis_pkg and sis_ram
`timescale 1ns / 1ps
`default_nettype none
module sis_dp import sis_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire op_type  op,
   input  wire req_type req_data,
   output dp_status_type st,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);
   logic [2:0]               cmd_ff, cmd_in;
   logic signed [DATA_W-1:0] cv_ff, cv_in;
   logic [CNT_W-1:0]         posin_ff, posin_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     ord_ff, ord_in;
   logic [CNT_W-1:0]         n_ff, n_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [CNT_W-1:0]         mid_ff, mid_in, i_ff, i_in, k_ff, k_in, s_ff, s_in;
   logic [CNT_W-1:0]         p_ff, p_in, pos_ff, pos_in;
   logic                     found_ff, found_in, bad_ff, bad_in;
   logic                     valid_ff, valid_in;
   logic [1:0]               status_ff, status_in;
   logic                     rfound_ff, rfound_in;
   logic [CNT_W-1:0]         where_ff, where_in;

   logic [CNT_W:0]           sum;
   logic [CNT_W-1:0]         mid_c;
   logic                     we;
   logic [ADDR_W-1:0]        waddr, raddr;
   logic [DATA_W-1:0]        wdata, rdata;
   logic signed [DATA_W-1:0] rval;

   sis_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_ram (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (waddr),
      .wr_data (wdata),
      .rd_addr (raddr),
      .rd_data (rdata)
   );

   assign rval  = $signed(rdata);
   assign sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_c = sum[CNT_W:1];

   assign st.cmd      = cmd_ff;
   assign st.ord      = ord_ff;
   assign st.full     = (cnt_ff >= CNT_W'(CAPACITY));
   assign st.pos_bad  = (posin_ff > cnt_ff);
   assign st.lo_lt_hi = (lo_ff < hi_ff);
   assign st.lo_lt_n  = (lo_ff < n_ff);
   assign st.i_lt_n   = (i_ff < n_ff);
   assign st.match    = (rval == cv_ff);
   assign st.found    = found_ff;
   assign st.need_uo  = ord_ff && (cnt_ff != '0) && (cmd_ff != CMD_INSERT);
   assign st.p_gt0    = (p_ff != '0);
   assign st.p_lt_cnt = (p_ff < cnt_ff);
   assign st.i_gt_p   = (i_ff > p_ff);
   assign st.s_lt_cnt = (s_ff < cnt_ff);

   assign rsp_valid        = valid_ff;
   assign rsp_data.status  = status_ff;
   assign rsp_data.found   = rfound_ff;
   assign rsp_data.where   = where_ff;
   assign rsp_data.count   = cnt_ff;
   assign rsp_data.ordered = ord_ff;

   always_comb begin
      cmd_in = cmd_ff; cv_in = cv_ff; posin_in = posin_ff; cnt_in = cnt_ff;
      ord_in = ord_ff; n_in = n_ff; lo_in = lo_ff; hi_in = hi_ff; mid_in = mid_ff;
      i_in = i_ff; k_in = k_ff; s_in = s_ff; p_in = p_ff; pos_in = pos_ff;
      found_in = found_ff; bad_in = bad_ff;
      valid_in = 1'b0; status_in = status_ff; rfound_in = rfound_ff;
      where_in = where_ff;
      we = 1'b0; waddr = '0; wdata = rdata; raddr = '0;
      unique case (op)
         OP_NONE: ;
         OP_ACCEPT: begin
            cmd_in = req_data.command; cv_in = req_data.value;
            posin_in = req_data.position;
            n_in = cnt_ff; lo_in = '0; hi_in = cnt_ff; i_in = '0; found_in = 1'b0;
         end
         OP_BS_RD: begin
            mid_in = mid_c;
            raddr  = mid_c[ADDR_W-1:0];
         end
         OP_BS_UPD: begin
            if (rval < cv_ff) lo_in = mid_ff + 1'b1;
            else              hi_in = mid_ff;
         end
         OP_EQ_RD: raddr = lo_ff[ADDR_W-1:0];
         OP_EQ_CHK: begin
            found_in = (rval == cv_ff);
            pos_in   = lo_ff;
         end
         OP_BS_MISS: begin
            found_in = 1'b0;
            pos_in   = lo_ff;
         end
         OP_LS_RD: raddr = i_ff[ADDR_W-1:0];
         OP_LS_CHK: begin
            if (rval == cv_ff) begin
               found_in = 1'b1;
               pos_in   = i_ff;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         OP_LS_MISS: begin
            found_in = 1'b0;
            pos_in   = '0;
         end
         OP_PLACE: begin
            priority if (cmd_ff == CMD_INSERT && ord_ff) p_in = pos_ff;
            else if (cmd_ff == CMD_AT)                  p_in = posin_ff;
            else                                        p_in = cnt_ff;
            i_in   = cnt_ff;
            bad_in = 1'b0;
         end
         OP_UOA_RD: raddr = ADDR_W'(p_ff - 1'b1);
         OP_UOA_CHK: if (cv_ff <= rval) bad_in = 1'b1;
         OP_UOB_RD: raddr = p_ff[ADDR_W-1:0];
         OP_UOB_CHK: if (cv_ff >= rval) bad_in = 1'b1;
         OP_UO_SET: if (st.need_uo) ord_in = ~bad_ff;
         OP_SH_RD: raddr = ADDR_W'(i_ff - 1'b1);
         OP_SH_WR: begin
            we    = 1'b1;
            waddr = i_ff[ADDR_W-1:0];
            i_in  = i_ff - 1'b1;
         end
         OP_INS_DONE: begin
            we = 1'b1; waddr = p_ff[ADDR_W-1:0]; wdata = cv_ff;
            cnt_in = cnt_ff + 1'b1;
            valid_in = 1'b1; status_in = ST_DONE; rfound_in = 1'b1; where_in = p_ff;
         end
         OP_SRT_INIT: begin
            s_in = '0;
            k_in = '0;
         end
         OP_SRT_RD: raddr = s_ff[ADDR_W-1:0];
         OP_SRT_LOAD: begin
            cv_in = rval; n_in = k_ff; lo_in = '0; hi_in = k_ff;
         end
         OP_SRT_SKIP: s_in = s_ff + 1'b1;
         OP_SRT_PLACE: begin
            p_in = pos_ff;
            i_in = k_ff;
         end
         OP_SRT_DONE: begin
            we = 1'b1; waddr = p_ff[ADDR_W-1:0]; wdata = cv_ff;
            k_in = k_ff + 1'b1;
            s_in = s_ff + 1'b1;
         end
         OP_SRT_END: begin
            cnt_in = k_ff; ord_in = 1'b1;
            valid_in = 1'b1; status_in = ST_DONE; rfound_in = 1'b0; where_in = '0;
         end
         OP_RSP_BADPOS: begin
            valid_in = 1'b1; status_in = ST_BADPOS; rfound_in = 1'b0; where_in = '0;
         end
         OP_RSP_DUP: begin
            valid_in = 1'b1; status_in = ST_DUP; rfound_in = 1'b1; where_in = pos_ff;
         end
         OP_RSP_FULL: begin
            valid_in = 1'b1; status_in = ST_FULL; rfound_in = 1'b0; where_in = '0;
         end
         OP_RSP_FIND: begin
            valid_in = 1'b1; status_in = ST_DONE; rfound_in = found_ff;
            where_in = found_ff ? pos_ff : '0;
         end
         OP_RSP_PLAIN: begin
            valid_in = 1'b1; status_in = ST_DONE; rfound_in = 1'b0; where_in = '0;
         end
         OP_CLEAR: begin
            cnt_in = '0; ord_in = 1'b1;
            valid_in = 1'b1; status_in = ST_DONE; rfound_in = 1'b0; where_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         ord_ff   <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         ord_ff   <= ord_in;
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in; cv_ff <= cv_in; posin_ff <= posin_in;
      n_ff <= n_in; lo_ff <= lo_in; hi_ff <= hi_in; mid_ff <= mid_in;
      i_ff <= i_in; k_ff <= k_in; s_ff <= s_in; p_ff <= p_in; pos_ff <= pos_in;
      found_ff <= found_in; bad_ff <= bad_in;
      status_ff <= status_in; rfound_ff <= rfound_in; where_ff <= where_in;
   end
endmodule
`default_nettype wire

FILE: rtl/sis_checker.sv
// port-level checks for the sorted integer set unit, bound to the top level
// depends on sis_pkg and sorted_integer_set_unit_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_integer_set_unit_assert.svh"
module sis_checker import sis_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_data
);
   `SISU_ASSERT_RST(a_idle_after_reset, reset |=> !busy, "busy after reset")
   `SISU_ASSERT(a_accept_busy, (start && !busy) |=> busy, "command taken but not busy")
   `SISU_ASSERT(a_rsp_idle, rsp_valid |-> !busy, "result shown while busy")
   `SISU_ASSERT(a_rsp_pulse, rsp_valid |=> !rsp_valid, "result strobe too long")
   `SISU_ASSERT(a_count_cap, rsp_valid |-> (rsp_data.count <= CNT_W'(CAPACITY)), "count big")
endmodule

bind sorted_integer_set_unit sis_checker u_sis_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
`default_nettype wire
